[rtl/ptw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ptw_pkg;

  // Default table store depth in 64-bit words.
  localparam int STORE_WORDS_DEF = 4096;

  // Entries per table level and the matching index width.
  localparam int ENTRIES_PER_LEVEL = 512;
  localparam int LEVEL_BITS        = $clog2(ENTRIES_PER_LEVEL);
  localparam int PAGE_SHIFT        = 12;

  // Field widths.
  localparam int VA_W         = 48;
  localparam int PA_W         = 52;
  localparam int ENTRY_W      = 64;
  localparam int STORE_IDX_W  = 12;
  localparam int PFN_W        = PA_W - PAGE_SHIFT;
  // A table word address is the frame number followed by the level index.
  localparam int WORD_ADDR_W  = PFN_W + LEVEL_BITS;

  // Entry flag bit positions.
  localparam int BIT_PRESENT  = 0;
  localparam int BIT_WRITABLE = 1;
  localparam int BIT_USER     = 2;
  localparam int BIT_HUGE     = 7;

  // Item mode codes.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_XLATE = 1'b1;

  // Level codes: the top table is level 3, the leaf table level 0.
  typedef enum logic [1:0] {
    LVL_PT   = 2'd0,
    LVL_PD   = 2'd1,
    LVL_PDPT = 2'd2,
    LVL_PML4 = 2'd3
  } ptw_level_t;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_NOT_PRESENT = 2'd1,
    STATUS_OUTSIDE     = 2'd2
  } ptw_status_t;

  typedef enum logic [1:0] {
    PAGE_4K = 2'd0,
    PAGE_2M = 2'd1,
    PAGE_1G = 2'd2
  } ptw_page_t;

  // Result of one address step: the table word and whether it lies past the store.
  typedef struct packed {
    logic                   outside;
    logic [WORD_ADDR_W-1:0] word;
  } ptw_step_t;

endpackage

`default_nettype wire

[rtl/ptw_store.sv]
`timescale 1ns / 1ps
`default_nettype none

module ptw_store
  import ptw_pkg::*;
#(
  parameter int STORE_WORDS = STORE_WORDS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [$clog2(STORE_WORDS)-1:0] wr_addr,
  input  wire logic [ENTRY_W-1:0]             wr_data,
  input  wire logic                           rd_en,
  input  wire logic [$clog2(STORE_WORDS)-1:0] rd_addr,
  output logic      [ENTRY_W-1:0]             rd_data,
  output logic                                clr_busy
);

  localparam int AW = $clog2(STORE_WORDS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_WORDS - 1);

  logic [ENTRY_W-1:0] mem [STORE_WORDS];
  logic [AW-1:0]      clr_addr_r;
  logic               clr_busy_r;
  logic [ENTRY_W-1:0] rd_data_r;

  // Clearing sweep after reset: one word a cycle, nothing present.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      if (clr_addr_r == LAST_ADDR) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  // Write port, taken by the sweep while it runs.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

`default_nettype wire

[rtl/ptw_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module ptw_step
  import ptw_pkg::*;
#(
  parameter int STORE_WORDS = STORE_WORDS_DEF
) (
  input  wire logic [PFN_W-1:0] base_pfn,
  input  wire logic [VA_W-1:0]  virt_address,
  input  wire ptw_level_t       level,
  output ptw_step_t             step
);

  localparam logic [WORD_ADDR_W-1:0] LIMIT = WORD_ADDR_W'(STORE_WORDS);

  logic [LEVEL_BITS-1:0] idx;

  // Pick the nine index bits that belong to this level.
  always_comb begin
    unique case (level)
      LVL_PML4: idx = virt_address[47:39];
      LVL_PDPT: idx = virt_address[38:30];
      LVL_PD:   idx = virt_address[29:21];
      LVL_PT:   idx = virt_address[20:12];
      default:  idx = virt_address[20:12];
    endcase
  end

  // The table base is page aligned, so the word address is a plain concatenation.
  assign step.word    = {base_pfn, idx};
  assign step.outside = ({base_pfn, idx} >= LIMIT);

endmodule

`default_nettype wire

[rtl/four_level_page_table_walker_core.sv]
// Sequence: a write word goes from acceptance straight to the finish state; a translation
// first reads L table words (L from 0 to 4), one per level, through the single store read port.
// The finish state registers the result in the output register once the receiver has taken
// the last one. Throughput: one word at a time; a new word is taken only back in idle.
// Reset: synchronous, active low; afterwards the store is swept to zero, and no input
// word is accepted until the sweep ends.
`timescale 1ns / 1ps
`default_nettype none

module four_level_page_table_walker_core
  import ptw_pkg::*;
#(
  parameter int STORE_WORDS = STORE_WORDS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [PA_W-1:0]        cfg_wdata,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_mode,
  input  wire logic [VA_W-1:0]        in_virt_address,
  input  wire logic [STORE_IDX_W-1:0] in_store_word_index,
  input  wire logic [ENTRY_W-1:0]     in_store_word,
  input  wire logic                   in_need_user,
  input  wire logic                   in_need_write,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  out_status,
  output logic [PA_W-1:0]             out_phys_address,
  output logic [ENTRY_W-1:0]          out_leaf_flags,
  output logic [1:0]                  out_page_size_code,
  output logic                        out_access_ok
);

  localparam int AW = $clog2(STORE_WORDS);
  localparam logic [WORD_ADDR_W-1:0] LIMIT = WORD_ADDR_W'(STORE_WORDS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_READ,
    ST_FIN
  } state_t;

  state_t              state_r, state_nxt;
  ptw_level_t          lvl_r, lvl_nxt;
  logic [PA_W-1:0]     root_r;
  logic [VA_W-1:0]     va_r, va_nxt;
  logic                need_user_r, need_user_nxt;
  logic                need_write_r, need_write_nxt;
  ptw_status_t         res_status_r, res_status_nxt;
  logic [PA_W-1:0]     res_phys_r, res_phys_nxt;
  logic [ENTRY_W-1:0]  res_flags_r, res_flags_nxt;
  ptw_page_t           res_size_r, res_size_nxt;
  logic                res_ok_r, res_ok_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic [PA_W-1:0]     out_phys_r, out_phys_nxt;
  logic [ENTRY_W-1:0]  out_flags_r, out_flags_nxt;
  logic [1:0]          out_size_r, out_size_nxt;
  logic                out_ok_r, out_ok_nxt;

  logic                accept;
  logic                clr_busy;
  logic                wr_en;
  logic                wr_outside;
  logic [AW-1:0]       wr_addr;
  logic                rd_en;
  logic [ENTRY_W-1:0]  entry;
  logic [PFN_W-1:0]    step_base;
  ptw_level_t          step_lvl;
  ptw_step_t           step;
  logic [ENTRY_W-1:0]  entry_flags;
  logic                entry_huge;

  assign in_ready = (state_r == ST_IDLE) && !clr_busy;
  assign accept   = in_valid && in_ready;

  // Store write from a write word; indexes past the store are dropped.
  assign wr_outside = {{(WORD_ADDR_W - STORE_IDX_W){1'b0}}, in_store_word_index} >= LIMIT;
  assign wr_addr    = AW'({{(WORD_ADDR_W - STORE_IDX_W){1'b0}}, in_store_word_index});
  assign wr_en      = accept && (in_mode == MODE_WRITE) && !wr_outside;

  ptw_store #(
    .STORE_WORDS (STORE_WORDS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (in_store_word),
    .rd_en    (rd_en),
    .rd_addr  (step.word[AW-1:0]),
    .rd_data  (entry),
    .clr_busy (clr_busy)
  );

  // The shared address step takes the root on the first level and the entry just read after.
  assign step_base = (state_r == ST_READ) ? entry[PA_W-1:PAGE_SHIFT] : root_r[PA_W-1:PAGE_SHIFT];
  assign step_lvl  = (state_r == ST_READ) ? ptw_level_t'(lvl_r - 2'd1) : lvl_r;

  ptw_step #(
    .STORE_WORDS (STORE_WORDS)
  ) u_step (
    .base_pfn     (step_base),
    .virt_address (va_r),
    .level        (step_lvl),
    .step         (step)
  );

  // Leaf flags keep everything but the frame address bits.
  assign entry_flags = {entry[ENTRY_W-1:PA_W], {PFN_W{1'b0}}, entry[PAGE_SHIFT-1:0]};
  assign entry_huge  = entry[BIT_HUGE] && ((lvl_r == LVL_PDPT) || (lvl_r == LVL_PD));

  // Walk sequencer and result formation.
  always_comb begin
    state_nxt      = state_r;
    lvl_nxt        = lvl_r;
    va_nxt         = va_r;
    need_user_nxt  = need_user_r;
    need_write_nxt = need_write_r;
    res_status_nxt = res_status_r;
    res_phys_nxt   = res_phys_r;
    res_flags_nxt  = res_flags_r;
    res_size_nxt   = res_size_r;
    res_ok_nxt     = res_ok_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_phys_nxt   = out_phys_r;
    out_flags_nxt  = out_flags_r;
    out_size_nxt   = out_size_r;
    out_ok_nxt     = out_ok_r;
    rd_en          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // Every result starts cleared; a write word finishes at once.
          res_status_nxt = STATUS_OK;
          res_phys_nxt   = '0;
          res_flags_nxt  = '0;
          res_size_nxt   = PAGE_4K;
          res_ok_nxt     = 1'b0;
          va_nxt         = in_virt_address;
          need_user_nxt  = in_need_user;
          need_write_nxt = in_need_write;
          lvl_nxt        = LVL_PML4;
          state_nxt      = (in_mode == MODE_XLATE) ? ST_START : ST_FIN;
        end
      end

      ST_START: begin
        if (step.outside) begin
          res_status_nxt = STATUS_OUTSIDE;
          state_nxt      = ST_FIN;
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_READ;
        end
      end

      ST_READ: begin
        priority if (!entry[BIT_PRESENT]) begin
          res_status_nxt = STATUS_NOT_PRESENT;
          state_nxt      = ST_FIN;
        end else if (entry_huge && (lvl_r == LVL_PDPT)) begin
          res_phys_nxt  = {entry[PA_W-1:30], va_r[29:0]};
          res_flags_nxt = entry_flags;
          res_size_nxt  = PAGE_1G;
          state_nxt     = ST_FIN;
        end else if (entry_huge) begin
          res_phys_nxt  = {entry[PA_W-1:21], va_r[20:0]};
          res_flags_nxt = entry_flags;
          res_size_nxt  = PAGE_2M;
          state_nxt     = ST_FIN;
        end else if (lvl_r == LVL_PT) begin
          res_phys_nxt  = {entry[PA_W-1:PAGE_SHIFT], va_r[PAGE_SHIFT-1:0]};
          res_flags_nxt = entry_flags;
          res_size_nxt  = PAGE_4K;
          res_ok_nxt    = (!need_user_r || entry[BIT_USER]) &&
                          (!need_write_r || entry[BIT_WRITABLE]);
          state_nxt     = ST_FIN;
        end else if (step.outside) begin
          res_status_nxt = STATUS_OUTSIDE;
          state_nxt      = ST_FIN;
        end else begin
          // Descend one level and read the next table word straight away.
          rd_en   = 1'b1;
          lvl_nxt = step_lvl;
        end
      end

      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_phys_nxt   = res_phys_r;
          out_flags_nxt  = res_flags_r;
          out_size_nxt   = res_size_r;
          out_ok_nxt     = res_ok_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, root, walk, result and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lvl_r       <= LVL_PML4;
      root_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        root_r <= cfg_wdata;
      end
    end
    va_r         <= va_nxt;
    need_user_r  <= need_user_nxt;
    need_write_r <= need_write_nxt;
    res_status_r <= res_status_nxt;
    res_phys_r   <= res_phys_nxt;
    res_flags_r  <= res_flags_nxt;
    res_size_r   <= res_size_nxt;
    res_ok_r     <= res_ok_nxt;
    out_status_r <= out_status_nxt;
    out_phys_r   <= out_phys_nxt;
    out_flags_r  <= out_flags_nxt;
    out_size_r   <= out_size_nxt;
    out_ok_r     <= out_ok_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_phys_address   = out_phys_r;
  assign out_leaf_flags     = out_flags_r;
  assign out_page_size_code = out_size_r;
  assign out_access_ok      = out_ok_r;

  // No word is taken while the store is still being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_ready)
    else $error("input word accepted during store clear");

  // Any accepted word keeps the block from being ready straight after its acceptance.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("block ready straight after accepting a word");

  // Faults carry no translation.
  a_fault_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STATUS_OK)) |->
      ((out_phys_address == '0) && (out_leaf_flags == '0) &&
       (out_page_size_code == PAGE_4K) && !out_access_ok))
    else $error("fault result with non-zero fields");

  // Access is granted only on a 4 KiB leaf of a good walk.
  a_access_small_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_access_ok) |->
      ((out_status == STATUS_OK) && (out_page_size_code == PAGE_4K)))
    else $error("access granted on a fault or huge page");

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import ptw_pkg::*;

  localparam logic [ENTRY_W-1:0] PTE_ADDR_MASK   = 64'h000F_FFFF_FFFF_F000;
  localparam logic [PA_W-1:0]    PA_FRAME_MASK   = 52'hF_FFFF_FFFF_F000;
  localparam logic [VA_W-1:0]    LEVEL_IDX_MASK  = VA_W'(ENTRIES_PER_LEVEL - 1);
  localparam int                 WATCHDOG_LIMIT  = 20000;
  localparam int                 N_PHASES        = 8;
  localparam int                 ITEMS_PER_PHASE = 105;
  localparam int                 N_HOT           = 3;

  // One input word as the sender presents it.
  typedef struct {
    logic                   mode;
    logic [VA_W-1:0]        va;
    logic [STORE_IDX_W-1:0] widx;
    logic [ENTRY_W-1:0]     wval;
    logic                   need_user;
    logic                   need_write;
  } walk_word_t;

  // One result word.
  typedef struct {
    ptw_status_t        status;
    logic [PA_W-1:0]    phys;
    logic [ENTRY_W-1:0] flags;
    ptw_page_t          size;
    logic               ok;
  } walk_result_t;

  // Ready patterns of the result receiver.
  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_EVERY_THIRD,
    RX_HOLD
  } rx_pattern_t;

  // Keeps a shadow of the table store and root, and the result words still owed.
  class walk_scoreboard;
    logic [ENTRY_W-1:0] table_mem [STORE_WORDS_DEF];
    logic [PA_W-1:0]    root_base;
    walk_result_t       owed_q[$];
    int n_errors, n_writes, n_4k, n_2m, n_1g, n_absent, n_outside, n_roots;

    function new();
      foreach (table_mem[i]) table_mem[i] = '0;
      root_base = '0;
    endfunction

    function void set_root(logic [PA_W-1:0] value);
      root_base = value;
      n_roots++;
    endfunction

    // Walks the shadow store exactly as the hardware should, or applies a store write.
    function walk_result_t translate(walk_word_t w);
      walk_result_t       r;
      logic [PA_W-1:0]    base;
      logic [ENTRY_W-1:0] entry;
      logic [63:0]        word_addr;
      logic [PA_W-1:0]    off_mask;
      int                 lv;
      int                 shift;
      r.status = STATUS_OK;
      r.phys   = '0;
      r.flags  = '0;
      r.size   = PAGE_4K;
      r.ok     = 1'b0;
      if (w.mode == MODE_WRITE) begin
        table_mem[w.widx] = w.wval;
        return r;
      end
      base  = root_base;
      entry = '0;
      for (lv = int'(LVL_PML4); lv >= int'(LVL_PT); lv--) begin
        shift     = PAGE_SHIFT + LEVEL_BITS * lv;
        word_addr = (64'(base[PA_W-1:PAGE_SHIFT]) << LEVEL_BITS)
                    + 64'((w.va >> shift) & LEVEL_IDX_MASK);
        if (word_addr >= 64'(STORE_WORDS_DEF)) begin
          r.status = STATUS_OUTSIDE;
          return r;
        end
        entry = table_mem[word_addr[STORE_IDX_W-1:0]];
        if (!entry[BIT_PRESENT]) begin
          r.status = STATUS_NOT_PRESENT;
          return r;
        end
        // A huge bit in the middle two levels ends the walk with a large page.
        if ((lv == LVL_PDPT || lv == LVL_PD) && entry[BIT_HUGE]) begin
          off_mask = (PA_W'(1) << shift) - PA_W'(1);
          r.phys   = (entry[PA_W-1:0] & PA_FRAME_MASK & ~off_mask) | (PA_W'(w.va) & off_mask);
          r.flags  = entry & ~PTE_ADDR_MASK;
          r.size   = (lv == LVL_PDPT) ? PAGE_1G : PAGE_2M;
          return r;
        end
        base = entry[PA_W-1:0] & PA_FRAME_MASK;
      end
      r.phys  = {entry[PA_W-1:PAGE_SHIFT], w.va[PAGE_SHIFT-1:0]};
      r.flags = entry & ~PTE_ADDR_MASK;
      r.ok    = (!w.need_user || entry[BIT_USER]) && (!w.need_write || entry[BIT_WRITABLE]);
      return r;
    endfunction

    // Called for every input word the block accepts.
    function void note_word(walk_word_t w);
      walk_result_t r;
      r = translate(w);
      owed_q.push_back(r);
      if (w.mode == MODE_WRITE) n_writes++;
      else if (r.status == STATUS_OUTSIDE) n_outside++;
      else if (r.status == STATUS_NOT_PRESENT) n_absent++;
      else if (r.size == PAGE_1G) n_1g++;
      else if (r.size == PAGE_2M) n_2m++;
      else n_4k++;
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      n_errors++;
    endtask

    // Compares one result word against the oldest owed translation.
    task check_result(walk_result_t got);
      walk_result_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("result word with nothing owed, status %0d", got.status));
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.phys !== want.phys)
        report($sformatf("phys_address got %h want %h", got.phys, want.phys));
      if (got.flags !== want.flags)
        report($sformatf("leaf_flags got %h want %h", got.flags, want.flags));
      if (got.size !== want.size)
        report($sformatf("page_size_code got %0d want %0d", got.size, want.size));
      if (got.ok !== want.ok)
        report($sformatf("access_ok got %0b want %0b", got.ok, want.ok));
    endtask

    task report_leftovers();
      if (owed_q.size() != 0)
        report($sformatf("%0d result words never arrived", owed_q.size()));
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [PA_W-1:0]        cfg_wdata;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_mode;
  logic [VA_W-1:0]        in_virt_address;
  logic [STORE_IDX_W-1:0] in_store_word_index;
  logic [ENTRY_W-1:0]     in_store_word;
  logic                   in_need_user;
  logic                   in_need_write;
  logic                   out_valid;
  logic                   out_ready;
  logic [1:0]             out_status;
  logic [PA_W-1:0]        out_phys_address;
  logic [ENTRY_W-1:0]     out_leaf_flags;
  logic [1:0]             out_page_size_code;
  logic                   out_access_ok;

  walk_scoreboard sb = new();
  walk_result_t   seen_result;
  int             burst_left;
  int             items_sent;
  int             idle_cycles;
  logic [8:0]     hot_idx [4][N_HOT];

  four_level_page_table_walker_core #(
    .STORE_WORDS(STORE_WORDS_DEF)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_virt_address    (in_virt_address),
    .in_store_word_index(in_store_word_index),
    .in_store_word      (in_store_word),
    .in_need_user       (in_need_user),
    .in_need_write      (in_need_write),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_phys_address   (out_phys_address),
    .out_leaf_flags     (out_leaf_flags),
    .out_page_size_code (out_page_size_code),
    .out_access_ok      (out_access_ok)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [VA_W-1:0] make_va(logic [8:0] i3, logic [8:0] i2, logic [8:0] i1,
                                               logic [8:0] i0, logic [11:0] off);
    return {i3, i2, i1, i0, off};
  endfunction

  // Store word of entry idx in the table held at frame f.
  function automatic logic [STORE_IDX_W-1:0] slot(logic [2:0] f, logic [8:0] idx);
    return {f, idx};
  endfunction

  function automatic logic [ENTRY_W-1:0] pte(logic [39:0] frame, logic [11:0] low);
    return {12'h000, frame, low};
  endfunction

  // A random entry that usually points at a table inside the store.
  function automatic logic [ENTRY_W-1:0] make_entry(logic [2:0] next_frame, int lv);
    logic [ENTRY_W-1:0] e;
    logic [39:0]        frame;
    frame = ($urandom_range(0, 9) == 0) ? 40'(rand64()) : 40'(next_frame);
    e = pte(frame, 12'($urandom));
    if ($urandom_range(0, 3) == 0) e[63:52] = 12'($urandom);
    e[BIT_PRESENT] = ($urandom_range(0, 9) != 0);
    if (lv == LVL_PDPT || lv == LVL_PD) e[BIT_HUGE] = ($urandom_range(0, 4) == 0);
    return e;
  endfunction

  // Presents one word, idling in random gaps between bursts, and waits for its acceptance.
  task automatic send_item(input walk_word_t w);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 5);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
    in_mode             = w.mode;
    in_virt_address     = w.va;
    in_store_word_index = w.widx;
    in_store_word       = w.wval;
    in_need_user        = w.need_user;
    in_need_write       = w.need_write;
    in_valid            = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(w);
    items_sent++;
    burst_left--;
  endtask

  task automatic send_write(input logic [STORE_IDX_W-1:0] idx, input logic [ENTRY_W-1:0] val);
    walk_word_t w;
    w.mode       = MODE_WRITE;
    w.va         = VA_W'(rand64());
    w.widx       = idx;
    w.wval       = val;
    w.need_user  = 1'($urandom);
    w.need_write = 1'($urandom);
    send_item(w);
  endtask

  task automatic send_xlate(input logic [VA_W-1:0] va, input logic nu, input logic nw);
    walk_word_t w;
    w.mode       = MODE_XLATE;
    w.va         = va;
    w.widx       = STORE_IDX_W'($urandom);
    w.wval       = rand64();
    w.need_user  = nu;
    w.need_write = nw;
    send_item(w);
  endtask

  // Drains the block, then writes the root register while nothing is in flight.
  task automatic load_root(input logic [PA_W-1:0] value);
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    while (sb.outstanding() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_root(value);
  endtask

  // Writes a chain of entries from the root down, then walks addresses along it.
  task automatic build_and_walk(input logic [PA_W-1:0] root);
    logic [2:0]      tframe;
    logic [2:0]      nframe;
    logic [8:0]      path [4];
    logic [VA_W-1:0] va;
    int              lv;
    int              n_walks;
    tframe = root[PAGE_SHIFT+2:PAGE_SHIFT];
    for (lv = int'(LVL_PML4); lv >= int'(LVL_PT); lv--) begin
      path[lv] = hot_idx[lv][$urandom_range(0, N_HOT - 1)];
      nframe   = 3'($urandom);
      if ($urandom_range(0, 3) != 0) send_write(slot(tframe, path[lv]), make_entry(nframe, lv));
      tframe = nframe;
    end
    n_walks = $urandom_range(1, 3);
    repeat (n_walks) begin
      va = make_va(path[3], path[2], path[1], path[0], 12'($urandom));
      // Now and then stray from the chain at one level.
      if ($urandom_range(0, 2) == 0) begin
        lv = $urandom_range(0, 3);
        va[PAGE_SHIFT + LEVEL_BITS*lv +: LEVEL_BITS] = hot_idx[lv][$urandom_range(0, N_HOT - 1)];
      end
      send_xlate(va, 1'($urandom), 1'($urandom));
    end
  endtask

  // Stray words: hot writes, hot walks and fully random words.
  task automatic send_noise();
    walk_word_t w;
    case ($urandom_range(0, 2))
      0: send_write(slot(3'($urandom), hot_idx[$urandom_range(0, 3)][$urandom_range(0, N_HOT - 1)]),
                    make_entry(3'($urandom), $urandom_range(0, 3)));
      1: send_xlate(make_va(hot_idx[3][$urandom_range(0, N_HOT - 1)],
                            hot_idx[2][$urandom_range(0, N_HOT - 1)],
                            hot_idx[1][$urandom_range(0, N_HOT - 1)],
                            hot_idx[0][$urandom_range(0, N_HOT - 1)], 12'($urandom)),
                    1'($urandom), 1'($urandom));
      default: begin
        w.mode       = 1'($urandom);
        w.va         = VA_W'(rand64());
        w.widx       = STORE_IDX_W'($urandom);
        w.wval       = rand64();
        w.need_user  = 1'($urandom);
        w.need_write = 1'($urandom);
        send_item(w);
      end
    endcase
  endtask

  // Result receiver: ready follows a pattern that changes every stretch.
  initial begin
    rx_pattern_t rx_mode;
    int          rx_left;
    out_ready = 1'b0;
    rx_mode   = RX_ALWAYS;
    rx_left   = 0;
    forever begin
      @(negedge clk);
      if (rx_left == 0) begin
        rx_mode = rx_pattern_t'($urandom_range(0, 3));
        rx_left = $urandom_range(4, 40);
      end
      rx_left--;
      case (rx_mode)
        RX_ALWAYS:      out_ready = 1'b1;
        RX_COIN:        out_ready = 1'($urandom);
        RX_EVERY_THIRD: out_ready = (rx_left % 3 == 0);
        default:        out_ready = (rx_left < 3);
      endcase
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_result.status = ptw_status_t'(out_status);
      seen_result.phys   = out_phys_address;
      seen_result.flags  = out_leaf_flags;
      seen_result.size   = ptw_page_t'(out_page_size_code);
      seen_result.ok     = out_access_ok;
      sb.check_result(seen_result);
    end
  end

  // Watchdog: ends the run if no word moves on either channel for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Main sequence.
  initial begin
    logic [PA_W-1:0] root;
    int              phase;
    int              phase_end;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_valid            = 1'b0;
    in_mode             = MODE_WRITE;
    in_virt_address     = '0;
    in_store_word_index = '0;
    in_store_word       = '0;
    in_need_user        = 1'b0;
    in_need_write       = 1'b0;
    burst_left          = 0;
    items_sent          = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: empty store, a full four-level chain, large pages and faults.
    load_root('0);
    send_xlate('0, 1'b1, 1'b1);
    send_xlate(48'hFFFF_FFFF_FFFF, 1'b0, 1'b0);
    send_write(slot(0, 0), pte(40'd1, 12'h007));
    send_write(slot(1, 0), pte(40'd2, 12'h007));
    send_write(slot(2, 0), pte(40'd3, 12'h007));
    // Leaf with every bit set, the PAT position included.
    send_write(slot(3, 5), 64'hFFFF_FFFF_FFFF_FFFF);
    send_xlate(make_va(0, 0, 0, 5, 12'hFFF), 1'b1, 1'b1);
    // Read-only supervisor page for the permission combinations.
    send_write(slot(3, 6), pte(40'd9, 12'h001));
    send_xlate(make_va(0, 0, 0, 6, 12'h123), 1'b0, 1'b0);
    send_xlate(make_va(0, 0, 0, 6, 12'h123), 1'b1, 1'b0);
    send_xlate(make_va(0, 0, 0, 6, 12'h123), 1'b0, 1'b1);
    send_xlate(make_va(0, 0, 0, 7, 12'h000), 1'b0, 1'b0);
    // 2 MiB page whose entry carries address bits below the page size.
    send_write(slot(2, 1), pte(40'hFF_FFFF_FFFF, 12'h087));
    send_xlate(make_va(0, 0, 1, 9'h1FF, 12'hFFF), 1'b1, 1'b1);
    // 1 GiB page with the no-execute bit set.
    send_write(slot(1, 1), pte(40'hA_BCDE_F012, 12'h083) | 64'h8000_0000_0000_0000);
    send_xlate(make_va(0, 1, 9'h1FF, 9'h1FF, 12'hFFF), 1'b1, 1'b1);
    // Entry pointing at a table just past the end of the store.
    send_write(slot(1, 2), pte(40'd8, 12'h003));
    send_xlate(make_va(0, 2, 0, 0, 12'h000), 1'b0, 1'b0);
    // Huge bit at the top level must be ignored.
    send_write(slot(0, 9'h1FF), pte(40'd1, 12'h087));
    send_xlate(make_va(9'h1FF, 0, 0, 5, 12'h0AB), 1'b0, 1'b1);
    // Root table outside the store, then a root with stray low bits.
    load_root(52'hF_FFFF_FFFF_FFFF);
    send_xlate('0, 1'b0, 1'b0);
    load_root(52'h0_0000_0000_0FFF);
    send_xlate(make_va(0, 0, 0, 5, 12'h000), 1'b1, 1'b1);

    // Random part: each phase picks a root and a few hot indices per level.
    for (phase = 0; phase < N_PHASES; phase++) begin
      case ($urandom_range(0, 9))
        0:       root = PA_W'(rand64());
        1:       root = {37'h0, 3'($urandom), 12'h000};
        default: root = {37'h0, 3'($urandom), 12'($urandom)};
      endcase
      load_root(root);
      foreach (hot_idx[lv, k]) hot_idx[lv][k] = 9'($urandom);
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 99) < 70) build_and_walk(root);
        else send_noise();
      end
    end

    // Drain and let the pipeline settle.
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    sb.report_leftovers();

    $display("Run covered %0d store writes and %0d walks over %0d root settings.",
             sb.n_writes, sb.n_4k + sb.n_2m + sb.n_1g + sb.n_absent + sb.n_outside, sb.n_roots);
    $display("Walks: %0d 4 KiB, %0d 2 MiB, %0d 1 GiB, %0d not present, %0d outside store.",
             sb.n_4k, sb.n_2m, sb.n_1g, sb.n_absent, sb.n_outside);
    if (sb.n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
